FILE: rtl/pppdc_pkg.sv
// ----------------------------------------------------------------------------
// pppdc_pkg
// Shared types, constants and helpers for the flag/escape deframer with the
// chained 16-bit frame checksum.
// ----------------------------------------------------------------------------
package pppdc_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAG   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE = 1'b1;

    // Reset values of the delimiter and escape registers.
    localparam logic [7:0] FLAG_RESET   = 8'h7E;
    localparam logic [7:0] ESCAPE_RESET = 8'h7D;

    // Result kinds.
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Number of released header bytes before payload starts.
    localparam logic [2:0] HDR_DONE = 3'd4;

    // Sum that marks a good frame.
    localparam logic [15:0] SUM_GOOD = 16'hFFFF;

    // One result transaction.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  address_field;
        logic [7:0]  control_field;
        logic [15:0] protocol_field;
        logic [15:0] checksum_field;
        logic        integrity_ok;
        logic        short_frame;
    } result_t;

    // Status of the result buffer as seen by the deframer.
    typedef struct packed {
        logic valid;
        logic full;
    } buf_status_t;

    // 16-bit add with carry in; bit 16 of the result is the carry out.
    function automatic logic [16:0] sum_add(input logic [15:0] a,
                                            input logic [15:0] b,
                                            input logic        cin);
        sum_add = {1'b0, a} + {1'b0, b} + {16'd0, cin};
    endfunction

endpackage

FILE: rtl/pppdc_out_buf.sv
// ----------------------------------------------------------------------------
// pppdc_out_buf
// Two-entry result buffer. Entry 0 drives the output channel; entry 1 holds
// a second result while the receiver stalls.
// ----------------------------------------------------------------------------
module pppdc_out_buf
    import pppdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    input  logic        pop,
    output buf_status_t status,
    output result_t     head
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    slot0_reg;
    result_t    slot1_reg;
    logic       do_pop;

    assign do_pop       = pop && (count_reg != 2'd0);
    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign head         = slot0_reg;

    // Occupancy count; a push only arrives when the buffer is not full.
    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entry storage: shift forward on a pop, fill the first free entry on a push.
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            if (count_reg == 2'd2)
            begin
                slot0_reg <= slot1_reg;
            end
            else if (push)
            begin
                slot0_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= push_data;
            end
            else
            begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

FILE: rtl/ppp_style_deframer_checksum_core.sv
// ----------------------------------------------------------------------------
// ppp_style_deframer_checksum_core
// Flag/escape byte-stream deframer with header capture, payload unescaping
// and a chained 16-bit checksum test.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/rx_byte) takes one raw line byte per
//   transaction. Each byte yields zero or one result transaction on the
//   output channel (out_valid/out_ready): a payload data byte (kind 0) or an
//   end-of-frame summary (kind 1) with header fields, received checksum,
//   integrity and short-frame flags.
//   The frame state is updated in the cycle a byte is accepted and its result
//   is registered at that same edge. One byte is taken every cycle while
//   in_ready is high; the rate is set by a single 16-bit add (two in series
//   on the closing flag) and the frame state registers.
//   Results go through a two-entry buffer. While the receiver stalls, the
//   block keeps taking bytes until both entries are filled, then drops
//   in_ready until an entry frees up.
//   The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets
//   the flag value (index 0) and escape value (index 1); it is always ready.
//   Reset clears the frame state and buffer, and restores flag 0x7E and
//   escape 0x7D.
// ----------------------------------------------------------------------------
module ppp_style_deframer_checksum_core
    import pppdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    // Input byte channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    // Result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   kind,
    output logic [7:0]             data_byte,
    output logic [7:0]             address_field,
    output logic [7:0]             control_field,
    output logic [15:0]            protocol_field,
    output logic [15:0]            checksum_field,
    output logic                   integrity_ok,
    output logic                   short_frame
);

    // Configuration registers
    logic [7:0] flag_reg;
    logic [7:0] escape_reg;

    // Frame state
    logic        in_frame_reg,    in_frame_next;
    logic        line_esc_reg,    line_esc_next;
    logic        pay_esc_reg,     pay_esc_next;
    logic [2:0]  rel_count_reg,   rel_count_next;
    logic [1:0]  held_count_reg,  held_count_next;
    logic [7:0]  hold0_reg,       hold0_next;
    logic [7:0]  hold1_reg,       hold1_next;
    logic [7:0]  address_reg,     address_next;
    logic [7:0]  control_reg,     control_next;
    logic [15:0] protocol_reg,    protocol_next;
    logic [15:0] sum_reg,         sum_next;
    logic        carry_reg,       carry_next;
    logic [7:0]  pend_byte_reg,   pend_byte_next;
    logic        pend_valid_reg,  pend_valid_next;

    // Step results
    logic        accept;
    logic        is_flag;
    logic        emit;
    result_t     result;
    logic [7:0]  rel_byte;
    logic [16:0] add_a;
    logic [16:0] add_b;
    logic [7:0]  chk_hi;
    logic [7:0]  chk_lo;
    logic        close_short;

    buf_status_t buf_status;
    result_t     buf_head;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !buf_status.full;
    assign cfg_ready = 1'b1;
    assign is_flag   = (rx_byte == flag_reg) && !line_esc_reg;
    assign rel_byte  = hold0_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= FLAG_RESET;
            escape_reg <= ESCAPE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FLAG:   flag_reg   <= cfg_data;
                CFG_ESCAPE: escape_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Close-time checksum bytes; missing held bytes read as zero.
    assign chk_hi      = (held_count_reg >= 2'd1) ? hold0_reg : 8'd0;
    assign chk_lo      = (held_count_reg == 2'd2) ? hold1_reg : 8'd0;
    assign close_short = !((rel_count_reg >= HDR_DONE) && (held_count_reg == 2'd2));

    // Per-byte frame processing.
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        line_esc_next   = line_esc_reg;
        pay_esc_next    = pay_esc_reg;
        rel_count_next  = rel_count_reg;
        held_count_next = held_count_reg;
        hold0_next      = hold0_reg;
        hold1_next      = hold1_reg;
        address_next    = address_reg;
        control_next    = control_reg;
        protocol_next   = protocol_reg;
        sum_next        = sum_reg;
        carry_next      = carry_reg;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        emit            = 1'b0;
        result          = '0;
        add_a           = '0;
        add_b           = '0;

        if (is_flag)
        begin
            if (in_frame_reg)
            begin
                // Closing flag: fold in the padded pending byte and the checksum.
                if (pend_valid_reg)
                begin
                    add_a = sum_add(sum_reg, {pend_byte_reg, 8'd0}, carry_reg);
                end
                else
                begin
                    add_a = {carry_reg, sum_reg};
                end
                add_b = sum_add(add_a[15:0], {chk_hi, chk_lo}, add_a[16]);

                emit                  = 1'b1;
                result.kind           = KIND_SUMMARY;
                result.address_field  = address_reg;
                result.control_field  = control_reg;
                result.protocol_field = protocol_reg;
                result.checksum_field = {chk_hi, chk_lo};
                result.integrity_ok   = !close_short && (add_b[15:0] == SUM_GOOD);
                result.short_frame    = close_short;

                // Every frame entry returns to its reset value.
                in_frame_next   = 1'b0;
                line_esc_next   = 1'b0;
                pay_esc_next    = 1'b0;
                rel_count_next  = 3'd0;
                held_count_next = 2'd0;
                hold0_next      = 8'd0;
                hold1_next      = 8'd0;
                address_next    = 8'd0;
                control_next    = 8'd0;
                protocol_next   = 16'd0;
                sum_next        = 16'd0;
                carry_next      = 1'b0;
                pend_byte_next  = 8'd0;
                pend_valid_next = 1'b0;
            end
        end
        else
        begin
            in_frame_next = 1'b1;
            line_esc_next = line_esc_reg ? 1'b0 : (rx_byte == escape_reg);

            if (held_count_reg == 2'd2)
            begin
                // Shift the holdback and release the oldest byte.
                hold0_next = hold1_reg;
                hold1_next = rx_byte;
                case (rel_count_reg)
                    3'd0:
                    begin
                        address_next   = rel_byte;
                        rel_count_next = 3'd1;
                    end
                    3'd1:
                    begin
                        control_next   = rel_byte;
                        rel_count_next = 3'd2;
                    end
                    3'd2:
                    begin
                        protocol_next  = {rel_byte, 8'd0};
                        rel_count_next = 3'd3;
                    end
                    3'd3:
                    begin
                        // Header complete: sum restarts with the two header words.
                        protocol_next  = {protocol_reg[15:8], rel_byte};
                        rel_count_next = HDR_DONE;
                        add_a          = sum_add({address_reg, control_reg},
                                                 {protocol_reg[15:8], rel_byte}, 1'b0);
                        sum_next       = add_a[15:0];
                        carry_next     = add_a[16];
                    end
                    default:
                    begin
                        if (!pay_esc_reg && (rel_byte == escape_reg))
                        begin
                            pay_esc_next = 1'b1;
                        end
                        else
                        begin
                            pay_esc_next = 1'b0;
                            if (pend_valid_reg)
                            begin
                                add_a           = sum_add(sum_reg, {pend_byte_reg, rel_byte},
                                                          carry_reg);
                                sum_next        = add_a[15:0];
                                carry_next      = add_a[16];
                                pend_valid_next = 1'b0;
                                pend_byte_next  = 8'd0;
                            end
                            else
                            begin
                                pend_byte_next  = rel_byte;
                                pend_valid_next = 1'b1;
                            end
                            emit             = 1'b1;
                            result.kind      = KIND_DATA;
                            result.data_byte = rel_byte;
                        end
                    end
                endcase
            end
            else
            begin
                // Still filling the two-byte holdback.
                if (held_count_reg == 2'd0)
                begin
                    hold0_next = rx_byte;
                end
                else
                begin
                    hold1_next = rx_byte;
                end
                held_count_next = held_count_reg + 2'd1;
            end
        end
    end

    // Frame state registers, updated once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            line_esc_reg   <= 1'b0;
            pay_esc_reg    <= 1'b0;
            rel_count_reg  <= 3'd0;
            held_count_reg <= 2'd0;
            hold0_reg      <= 8'd0;
            hold1_reg      <= 8'd0;
            address_reg    <= 8'd0;
            control_reg    <= 8'd0;
            protocol_reg   <= 16'd0;
            sum_reg        <= 16'd0;
            carry_reg      <= 1'b0;
            pend_byte_reg  <= 8'd0;
            pend_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_frame_reg   <= in_frame_next;
            line_esc_reg   <= line_esc_next;
            pay_esc_reg    <= pay_esc_next;
            rel_count_reg  <= rel_count_next;
            held_count_reg <= held_count_next;
            hold0_reg      <= hold0_next;
            hold1_reg      <= hold1_next;
            address_reg    <= address_next;
            control_reg    <= control_next;
            protocol_reg   <= protocol_next;
            sum_reg        <= sum_next;
            carry_reg      <= carry_next;
            pend_byte_reg  <= pend_byte_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Result buffer between the deframer and the output channel.
    pppdc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_data (result),
        .pop       (out_ready),
        .status    (buf_status),
        .head      (buf_head)
    );

    assign out_valid      = buf_status.valid;
    assign kind           = buf_head.kind;
    assign data_byte      = buf_head.data_byte;
    assign address_field  = buf_head.address_field;
    assign control_field  = buf_head.control_field;
    assign protocol_field = buf_head.protocol_field;
    assign checksum_field = buf_head.checksum_field;
    assign integrity_ok   = buf_head.integrity_ok;
    assign short_frame    = buf_head.short_frame;

    // A closing flag always leaves a result waiting in the next cycle.
    a_close_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_flag && in_frame_reg) |=> out_valid)
        else $error("closing flag produced no result");

    // After a closing flag the block is between frames with an empty holdback.
    a_close_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_flag && in_frame_reg) |=>
            (!in_frame_reg && held_count_reg == 2'd0 && rel_count_reg == 3'd0))
        else $error("frame state not cleared at close");

    // Counters stay within their ranges.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != 2'd3) && (rel_count_reg <= HDR_DONE))
        else $error("frame counter out of range");

    // Payload is only emitted once the header has been taken.
    a_data_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && (result.kind == KIND_DATA)) |-> (rel_count_reg == HDR_DONE))
        else $error("payload byte emitted before header complete");

endmodule
